// ----- sv/dld_pkg.sv -----
// Shared types and constants for the Damerau-Levenshtein distance engine.
package dld_pkg;

	localparam int MAX_LEN_DEFAULT = 64;
	localparam int OP_W            = 2;
	localparam int SYM_W           = 21;
	localparam int DIST_W          = 8;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND_A = 2'd0,
		OP_APPEND_B = 2'd1,
		OP_COMPARE  = 2'd2,
		OP_NONE     = 2'd3
	} opcode_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_TR   = 5'b00100,
		S_UPD  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

endpackage

// ----- sv/dld_item_if.sv -----
// Input channel: opcode and code point beats.
interface dld_item_if;
	logic                        valid;
	logic                        ready;
	logic [dld_pkg::OP_W-1:0]    opcode;
	logic [dld_pkg::SYM_W-1:0]   symbol;

	modport source(output valid, output opcode, output symbol, input ready);
	modport sink(input valid, input opcode, input symbol, output ready);
endinterface

// ----- sv/dld_result_if.sv -----
// Output channel: distance and overflow flag beats.
interface dld_result_if;
	logic                        valid;
	logic                        ready;
	logic [dld_pkg::DIST_W-1:0]  distance;
	logic                        overflowed;

	modport source(output valid, output distance, output overflowed, input ready);
	modport sink(input valid, input distance, input overflowed, output ready);
endinterface

// ----- sv/dld_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- sv/damerau_levenshtein_distance.sv -----
// Top level of the unrestricted Damerau-Levenshtein distance engine.
//
// Usage:
//   item channel: each beat carries opcode and symbol. APPEND_A / APPEND_B add
//   a 21-bit code point to the first / second string; an append to a full
//   string (MAX_LEN symbols) is dropped and sets the overflow flag. COMPARE
//   computes the distance and clears both strings and the flag. Opcode 3 is
//   taken and ignored.
//   result channel: one beat per compare with distance (saturated at 255) and
//   overflowed.
// Cell: each matrix cell steps through the read, transposition and update
//   states, using the single read port of the matrix RAM (up cell, then the
//   transposition cell) and one shared min/add unit. An empty string skips
//   the matrix and goes straight to the result.
// Throughput: item.ready is high only in the idle state; appends sustain one
//   beat per cycle. The block is busy for the whole compare.
// Reset: arst_n clears lengths, flag, state and the pending result. String,
//   matrix and last-row stores are not cleared; row one reads no stale entry.
// Stall: a finished result waits in the output register; appends are taken
//   meanwhile, and a further compare holds in its final state until the
//   pending result beat is taken.
module damerau_levenshtein_distance #(
	parameter int MAX_LEN = dld_pkg::MAX_LEN_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	dld_item_if.sink      item,
	dld_result_if.source  result
);
	localparam int LW  = $clog2(MAX_LEN + 1);            // lengths / row numbers
	localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int VW  = $clog2(2 * MAX_LEN + 1);        // cell values
	localparam int TW  = VW + 2;                         // transposition sum
	localparam int DD  = MAX_LEN * MAX_LEN;              // interior cells only
	localparam int DAW = (DD > 1) ? $clog2(DD) : 1;

	dld_pkg::state_t state_q;

	logic [LW-1:0] n_q, m_q;
	logic          ovf_seen_q;
	logic [IW-1:0] i0_q, j0_q;
	logic [VW-1:0] left_q, diag_q, up_q, res_q;
	logic [LW-1:0] mcol_q, k_q, l_q;
	logic          eq_q;
	logic          out_valid_q;
	logic [dld_pkg::DIST_W-1:0] dist_q;
	logic          ovf_out_q;

	logic accept;
	assign item.ready = (state_q == dld_pkg::S_IDLE);
	assign accept     = item.valid && item.ready;

	assign result.valid      = out_valid_q;
	assign result.distance   = dist_q;
	assign result.overflowed = ovf_out_q;

	// string stores
	logic [dld_pkg::SYM_W-1:0] a_rdata, b_rdata;
	logic a_we, b_we;
	assign a_we = accept && (item.opcode == dld_pkg::OP_APPEND_A) && (n_q < LW'(MAX_LEN));
	assign b_we = accept && (item.opcode == dld_pkg::OP_APPEND_B) && (m_q < LW'(MAX_LEN));

	dld_ram #(.WIDTH(dld_pkg::SYM_W), .DEPTH(MAX_LEN)) u_str_a (
		.clk(clk), .we(a_we), .waddr(n_q[IW-1:0]), .wdata(item.symbol),
		.raddr(i0_q), .rdata(a_rdata)
	);
	dld_ram #(.WIDTH(dld_pkg::SYM_W), .DEPTH(MAX_LEN)) u_str_b (
		.clk(clk), .we(b_we), .waddr(m_q[IW-1:0]), .wdata(item.symbol),
		.raddr(j0_q), .rdata(b_rdata)
	);

	// last row in which each column's symbol appeared in the first string
	logic          eq_b;
	logic [LW-1:0] k_rdata, k_eff, k_wdata;
	logic          k_we;
	assign eq_b    = (a_rdata == b_rdata);
	assign k_eff   = (i0_q == '0) ? '0 : k_rdata;
	assign k_we    = (state_q == dld_pkg::S_TR) && ((i0_q == '0) || eq_b);
	assign k_wdata = eq_b ? (LW'(i0_q) + LW'(1)) : '0;

	dld_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_last_row (
		.clk(clk), .we(k_we), .waddr(j0_q), .wdata(k_wdata),
		.raddr(j0_q), .rdata(k_rdata)
	);

	// interior matrix cells, cell (i0, j0) holds D[i0+2][j0+2]
	logic [DAW-1:0] d_up_addr, d_tr_addr, d_raddr, d_waddr;
	logic [VW-1:0]  d_rdata;
	logic           d_we;
	logic [VW-1:0]  best;

	assign d_up_addr = DAW'(i0_q - IW'(1)) * DAW'(MAX_LEN) + DAW'(j0_q);
	assign d_tr_addr = DAW'(k_eff - LW'(2)) * DAW'(MAX_LEN) + DAW'(mcol_q - LW'(2));
	assign d_raddr   = (state_q == dld_pkg::S_TR) ? d_tr_addr : d_up_addr;
	assign d_waddr   = DAW'(i0_q) * DAW'(MAX_LEN) + DAW'(j0_q);
	assign d_we      = (state_q == dld_pkg::S_UPD);

	dld_ram #(.WIDTH(VW), .DEPTH(DD)) u_matrix (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(best),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	// shared cell update: min of substitution, insertion, deletion, transposition
	logic [TW-1:0] big, tr_base, trans, c_sub, c_ins, c_del, m1, m2;
	assign big = TW'(n_q) + TW'(m_q);

	always_comb begin
		priority if (k_q == '0 || l_q == '0) begin
			tr_base = big;
		end else if (k_q == LW'(1)) begin
			tr_base = TW'(l_q - LW'(1));
		end else if (l_q == LW'(1)) begin
			tr_base = TW'(k_q - LW'(1));
		end else begin
			tr_base = TW'(d_rdata);
		end
	end

	assign trans = tr_base + TW'(i0_q) + TW'(j0_q) + TW'(1) - TW'(k_q) - TW'(l_q);
	assign c_sub = TW'(diag_q) + TW'(!eq_q);
	assign c_ins = TW'(left_q) + TW'(1);
	assign c_del = TW'(up_q) + TW'(1);
	assign m1    = (c_ins < c_sub) ? c_ins : c_sub;
	assign m2    = (c_del < m1) ? c_del : m1;
	assign best  = VW'((trans < m2) ? trans : m2);

	logic row_end, last_row, can_load;
	assign row_end  = (LW'(j0_q) + LW'(1)) == m_q;
	assign last_row = (LW'(i0_q) + LW'(1)) == n_q;
	assign can_load = !out_valid_q || result.ready;

	logic [VW-1:0] sat_lim;
	assign sat_lim = VW'(255);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dld_pkg::S_IDLE;
			n_q         <= '0;
			m_q         <= '0;
			ovf_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// in the final state the load below decides the flag
			if (out_valid_q && result.ready && state_q != dld_pkg::S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				dld_pkg::S_IDLE: begin
					if (accept) begin
						unique case (item.opcode)
							dld_pkg::OP_APPEND_A: begin
								if (a_we) n_q <= n_q + LW'(1);
								else      ovf_seen_q <= 1'b1;
							end
							dld_pkg::OP_APPEND_B: begin
								if (b_we) m_q <= m_q + LW'(1);
								else      ovf_seen_q <= 1'b1;
							end
							dld_pkg::OP_COMPARE: begin
								if (n_q == '0 || m_q == '0) begin
									res_q   <= VW'(n_q) + VW'(m_q);
									state_q <= dld_pkg::S_DONE;
								end else begin
									i0_q    <= '0;
									j0_q    <= '0;
									left_q  <= VW'(1);
									diag_q  <= '0;
									mcol_q  <= '0;
									state_q <= dld_pkg::S_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				dld_pkg::S_RD: begin
					state_q <= dld_pkg::S_TR;
				end
				dld_pkg::S_TR: begin
					up_q  <= (i0_q == '0) ? VW'(j0_q) + VW'(1) : d_rdata;
					k_q   <= k_eff;
					l_q   <= mcol_q;
					eq_q  <= eq_b;
					if (eq_b) mcol_q <= LW'(j0_q) + LW'(1);
					state_q <= dld_pkg::S_UPD;
				end
				dld_pkg::S_UPD: begin
					if (!row_end) begin
						left_q  <= best;
						diag_q  <= up_q;
						j0_q    <= j0_q + IW'(1);
						state_q <= dld_pkg::S_RD;
					end else if (last_row) begin
						res_q   <= best;
						state_q <= dld_pkg::S_DONE;
					end else begin
						i0_q    <= i0_q + IW'(1);
						j0_q    <= '0;
						left_q  <= VW'(i0_q) + VW'(2);
						diag_q  <= VW'(i0_q) + VW'(1);
						mcol_q  <= '0;
						state_q <= dld_pkg::S_RD;
					end
				end
				dld_pkg::S_DONE: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						dist_q      <= (res_q > sat_lim) ? {dld_pkg::DIST_W{1'b1}}
						                                 : dld_pkg::DIST_W'(res_q);
						ovf_out_q   <= ovf_seen_q;
						n_q         <= '0;
						m_q         <= '0;
						ovf_seen_q  <= 1'b0;
						state_q     <= dld_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= dld_pkg::S_IDLE;
				end
			endcase
		end
	end

	// column index stays inside the second string during a cell
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dld_pkg::S_UPD) |-> (LW'(j0_q) < m_q))
		else $error("column index beyond second string");

	// transposition row comes strictly from an earlier row
	a_k_earlier: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dld_pkg::S_UPD) |-> (k_q <= LW'(i0_q)))
		else $error("last-seen row not before current row");

	// transposition column comes strictly from an earlier column
	a_l_earlier: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dld_pkg::S_UPD) |-> (l_q <= LW'(j0_q)))
		else $error("match column not before current column");

	// loading a result clears both strings and the flag
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dld_pkg::S_DONE && can_load) |=>
		(n_q == '0 && m_q == '0 && !ovf_seen_q && out_valid_q))
		else $error("compare did not clear state");
endmodule

// ----- tb/sv/damerau_levenshtein_distance_tb.sv -----
// Self-checking testbench for the Damerau-Levenshtein distance engine.
`timescale 1ns / 1ps

module damerau_levenshtein_distance_tb;

	localparam int MAX_LEN  = dld_pkg::MAX_LEN_DEFAULT;
	localparam int SYM_W    = dld_pkg::SYM_W;
	localparam int N_ITEMS  = 1100;
	localparam int CYC_MAX  = 4000000;
	localparam int DIM      = MAX_LEN + 2;

	typedef struct packed {
		logic [dld_pkg::OP_W-1:0] op;
		logic [SYM_W-1:0]         sym;
	} item_beat_t;

	typedef struct packed {
		logic [dld_pkg::DIST_W-1:0] dval;
		logic                       ovf;
	} dist_beat_t;

	// directed row: beat plus an optional typed-in expectation
	typedef struct {
		item_beat_t beat;
		bit         has_exp;
		dist_beat_t exp;
	} dir_row_t;

	logic clk;
	logic arst_n;

	dld_item_if   item ();
	dld_result_if result ();

	damerau_levenshtein_distance #(.MAX_LEN(MAX_LEN)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// predictor state
	logic [SYM_W-1:0] str_a [MAX_LEN];
	logic [SYM_W-1:0] str_b [MAX_LEN];
	int               len_a, len_b;
	bit               ovf_flag;

	dist_beat_t dist_q [$];      // expected distances, oldest first
	dist_beat_t typed_q [$];     // typed-in expectations for directed compares
	bit         typed_has [$];

	int  errors;
	int  mismatches;
	int  cycles;
	bit  quiet_tail;             // last part of the run: no idling
	bit  hold_rx;                // long receiver hold-off
	bit  stim_done;

	// Full-matrix unrestricted Damerau-Levenshtein, last row per symbol
	function automatic int dl_distance();
		int d [DIM][DIM];
		logic [SYM_W-1:0] seen_sym [MAX_LEN];
		int seen_row [MAX_LEN];
		int n_seen;
		int big, k, l, cost, best, trans, mcol;
		big = len_a + len_b;
		n_seen = 0;
		d[0][0] = big;
		for (int i = 0; i <= len_a; i++) begin
			d[i+1][1] = i;
			d[i+1][0] = big;
		end
		for (int j = 0; j <= len_b; j++) begin
			d[1][j+1] = j;
			d[0][j+1] = big;
		end
		for (int i = 1; i <= len_a; i++) begin
			mcol = 0;
			for (int j = 1; j <= len_b; j++) begin
				k = 0;
				for (int e = 0; e < n_seen; e++)
					if (seen_sym[e] == str_b[j-1]) k = seen_row[e];
				l = mcol;
				cost = 1;
				if (str_a[i-1] == str_b[j-1]) begin
					mcol = j;
					cost = 0;
				end
				best = d[i][j] + cost;
				if (d[i+1][j] + 1 < best) best = d[i+1][j] + 1;
				if (d[i][j+1] + 1 < best) best = d[i][j+1] + 1;
				trans = d[k][l] + (i - k - 1) + 1 + (j - l - 1);
				if (trans < best) best = trans;
				d[i+1][j+1] = best;
			end
			begin
				bit hit;
				hit = 0;
				for (int e = 0; e < n_seen; e++)
					if (seen_sym[e] == str_a[i-1]) begin
						seen_row[e] = i;
						hit = 1;
					end
				if (!hit) begin
					seen_sym[n_seen] = str_a[i-1];
					seen_row[n_seen] = i;
					n_seen++;
				end
			end
		end
		return d[len_a+1][len_b+1];
	endfunction

	// advance predictor by one accepted beat
	task automatic predict_beat(input item_beat_t b);
		dist_beat_t r;
		int dv;
		case (dld_pkg::opcode_t'(b.op))
			dld_pkg::OP_APPEND_A: begin
				if (len_a < MAX_LEN) str_a[len_a++] = b.sym;
				else ovf_flag = 1;
			end
			dld_pkg::OP_APPEND_B: begin
				if (len_b < MAX_LEN) str_b[len_b++] = b.sym;
				else ovf_flag = 1;
			end
			dld_pkg::OP_COMPARE: begin
				dv = dl_distance();
				r.dval = (dv > 255) ? 8'd255 : dv[7:0];
				r.ovf = ovf_flag;
				dist_q.push_back(r);
				len_a = 0;
				len_b = 0;
				ovf_flag = 0;
			end
			default: ;
		endcase
	endtask

	// ---------------- sender ----------------
	item_beat_t send_q [$];
	bit         send_typed [$];
	dist_beat_t send_exp [$];

	task automatic queue_beat(input logic [1:0] op, input logic [SYM_W-1:0] sym);
		item_beat_t b;
		b.op = op;
		b.sym = sym;
		send_q.push_back(b);
	endtask

	// driver: offer the head of send_q, random idle bursts
	int tx_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item.valid  <= 1'b0;
			item.opcode <= '0;
			item.symbol <= '0;
			tx_gap = 0;
		end else begin
			if (item.valid && item.ready) begin
				predict_beat({item.opcode, item.symbol});
				void'(send_q.pop_front());
			end
			if (item.valid && !item.ready) begin
				// offered beat still waiting: keep it steady
			end else if (tx_gap > 0) begin
				tx_gap--;
				item.valid <= 1'b0;
			end else if (send_q.size() > 0) begin
				if (!quiet_tail && !hold_rx && $urandom_range(0, 9) == 0) begin
					tx_gap = $urandom_range(1, 12);
					item.valid <= 1'b0;
				end else begin
					item.valid  <= 1'b1;
					item.opcode <= send_q[0].op;
					item.symbol <= send_q[0].sym;
				end
			end else begin
				item.valid <= 1'b0;
			end
		end
	end

	// ---------------- receiver ----------------
	int rx_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			rx_gap = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (dist_q.size() == 0) begin
					errors++;
					if (mismatches++ < 10)
						$display("unexpected result beat dist=%0d ovf=%0b",
							result.distance, result.overflowed);
				end else begin
					dist_beat_t e;
					e = dist_q.pop_front();
					// typed-in directed expectations are checked as well
					if (typed_has.size() > 0) begin
						if (typed_has.pop_front()) begin
							dist_beat_t t;
							t = typed_q.pop_front();
							if (t !== e) begin
								errors++;
								if (mismatches++ < 10)
									$display("typed expectation differs: %0d/%0b vs %0d/%0b",
										t.dval, t.ovf, e.dval, e.ovf);
							end
						end
					end
					if (result.distance !== e.dval || result.overflowed !== e.ovf) begin
						errors++;
						if (mismatches++ < 10)
							$display("mismatch: exp dist=%0d ovf=%0b got dist=%0d ovf=%0b",
								e.dval, e.ovf, result.distance, result.overflowed);
					end
				end
			end
			if (hold_rx) result.ready <= 1'b0;
			else if (rx_gap > 0) begin
				rx_gap--;
				result.ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				rx_gap = $urandom_range(1, 12);
				result.ready <= 1'b0;
			end else result.ready <= 1'b1;
		end
	end

	// ---------------- timeout ----------------
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_MAX) begin
			$display("damerau_levenshtein_distance test failed");
			$finish;
		end
	end

	// random symbol: mostly from a small alphabet so matches/transpositions occur
	function automatic logic [SYM_W-1:0] rand_sym(input int alpha);
		if ($urandom_range(0, 19) == 0) return SYM_W'($urandom());
		return SYM_W'($urandom_range(0, alpha - 1) + 'h61);
	endfunction

	// one well-formed pair of strings plus compare
	task automatic queue_pair(input int na, input int nb, input int alpha);
		for (int i = 0; i < na; i++) queue_beat(dld_pkg::OP_APPEND_A, rand_sym(alpha));
		for (int i = 0; i < nb; i++) queue_beat(dld_pkg::OP_APPEND_B, rand_sym(alpha));
		queue_beat(dld_pkg::OP_COMPARE, SYM_W'($urandom()));
	endtask

	task automatic wait_drain();
		while (send_q.size() > 0 || dist_q.size() > 0) @(posedge clk);
	endtask

	dir_row_t dir_tab [$];

	task automatic add_row(input logic [1:0] op, input logic [SYM_W-1:0] sym,
			input bit has, input logic [dld_pkg::DIST_W-1:0] dv, input logic ov);
		dir_row_t r;
		r.beat.op = op;
		r.beat.sym = sym;
		r.has_exp = has;
		r.exp.dval = dv;
		r.exp.ovf = ov;
		dir_tab.push_back(r);
	endtask

	int n_sent;
	int plen;

	initial begin
		errors = 0;
		mismatches = 0;
		cycles = 0;
		quiet_tail = 0;
		hold_rx = 0;
		stim_done = 0;
		len_a = 0;
		len_b = 0;
		ovf_flag = 0;
		item.valid = 1'b0;
		item.opcode = '0;
		item.symbol = '0;
		result.ready = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed table: empty compare, extreme symbols, opcode 3, transposition
		add_row(dld_pkg::OP_COMPARE, '0, 1, 8'd0, 1'b0);          // both empty
		add_row(dld_pkg::OP_APPEND_A, 21'h1FFFFF, 0, 0, 0);       // raw 21-bit value
		add_row(dld_pkg::OP_APPEND_A, 21'h000000, 0, 0, 0);
		add_row(dld_pkg::OP_COMPARE, 21'h1FFFFF, 1, 8'd2, 1'b0);  // second empty
		add_row(dld_pkg::OP_APPEND_B, 21'h10FFFF, 0, 0, 0);
		add_row(dld_pkg::OP_NONE, 21'h1FFFFF, 0, 0, 0);           // ignored
		add_row(dld_pkg::OP_COMPARE, '0, 1, 8'd1, 1'b0);          // first empty
		add_row(dld_pkg::OP_APPEND_A, 21'h61, 0, 0, 0);
		add_row(dld_pkg::OP_APPEND_A, 21'h62, 0, 0, 0);
		add_row(dld_pkg::OP_APPEND_B, 21'h62, 0, 0, 0);
		add_row(dld_pkg::OP_APPEND_B, 21'h61, 0, 0, 0);
		add_row(dld_pkg::OP_COMPARE, '0, 1, 8'd1, 1'b0);          // adjacent swap
		add_row(dld_pkg::OP_APPEND_A, 21'h63, 0, 0, 0);
		add_row(dld_pkg::OP_APPEND_A, 21'h61, 0, 0, 0);
		add_row(dld_pkg::OP_APPEND_B, 21'h61, 0, 0, 0);
		add_row(dld_pkg::OP_APPEND_B, 21'h62, 0, 0, 0);
		add_row(dld_pkg::OP_APPEND_B, 21'h63, 0, 0, 0);
		add_row(dld_pkg::OP_COMPARE, '0, 0, 0, 0);                // predictor only
		foreach (dir_tab[r]) begin
			send_q.push_back(dir_tab[r].beat);
			if (dir_tab[r].beat.op == dld_pkg::OP_COMPARE) begin
				typed_has.push_back(dir_tab[r].has_exp);
				if (dir_tab[r].has_exp) typed_q.push_back(dir_tab[r].exp);
			end
		end
		wait_drain();

		// string-full case: first string overfilled, then both full
		for (int i = 0; i < MAX_LEN + 2; i++) queue_beat(dld_pkg::OP_APPEND_A, 21'h41);
		queue_beat(dld_pkg::OP_COMPARE, '0);
		for (int i = 0; i < MAX_LEN; i++) begin
			queue_beat(dld_pkg::OP_APPEND_A, rand_sym(4));
			queue_beat(dld_pkg::OP_APPEND_B, rand_sym(4));
		end
		queue_beat(dld_pkg::OP_APPEND_B, 21'h42);
		queue_beat(dld_pkg::OP_COMPARE, '0);
		wait_drain();

		// pressure: receiver held while compares pile up behind the output
		hold_rx = 1;
		for (int p = 0; p < 6; p++) queue_pair(2, 2, 3);
		repeat (400) @(posedge clk);
		hold_rx = 0;
		wait_drain();

		// random part: mostly short well-formed pairs, some noise
		n_sent = 0;
		while (n_sent < N_ITEMS) begin
			if (n_sent > N_ITEMS * 4 / 5) quiet_tail = 1;
			if ($urandom_range(0, 9) == 0) begin
				item_beat_t b;
				b.op = 2'($urandom_range(0, 3));
				b.sym = SYM_W'($urandom());
				send_q.push_back(b);
				if (b.op != dld_pkg::OP_NONE) n_sent++;
			end else begin
				int na, nb;
				plen = ($urandom_range(0, 29) == 0) ? MAX_LEN + 1 : 8;
				na = $urandom_range(0, plen);
				nb = $urandom_range(0, plen);
				queue_pair(na, nb, $urandom_range(1, 6));
				n_sent += na + nb + 1;
			end
			while (send_q.size() > 16) @(posedge clk);
		end
		queue_beat(dld_pkg::OP_COMPARE, '0);
		wait_drain();
		repeat (50) @(posedge clk);

		if (errors == 0 && dist_q.size() == 0)
			$display("damerau_levenshtein_distance test passed");
		else
			$display("damerau_levenshtein_distance test failed");
		$finish;
	end

endmodule
